@@ hdl/dhcp_pkg.sv @@
// ----------------------------------------------------------------------------
// DHCP request parser package
// Shared widths, constants and the summary record passed from the front end.
// ----------------------------------------------------------------------------
package dhcp_pkg;

    localparam int HOSTNAME_MAX_DEF = 31;
    localparam int MIN_LEN_DEF      = 240;
    localparam int OPT_START        = 240;
    localparam int LEN_SAT          = 1023;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_END    = 8'd255;
    localparam logic [7:0] OPT_MSG    = 8'd53;
    localparam logic [7:0] OPT_REQIP  = 8'd50;
    localparam logic [7:0] OPT_SRVID  = 8'd54;
    localparam logic [7:0] OPT_HOST   = 8'd12;

    localparam logic [7:0] COOKIE_0 = 8'h63;
    localparam logic [7:0] COOKIE_1 = 8'h82;
    localparam logic [7:0] COOKIE_2 = 8'h53;
    localparam logic [7:0] COOKIE_3 = 8'h63;

    typedef struct packed {
        logic        ok;
        logic [31:0] xid;
        logic [15:0] flags;
        logic [31:0] ciaddr;
        logic [47:0] mac;
        logic [7:0]  msg_type;
        logic [31:0] req_ip;
        logic [31:0] srv_id;
        logic [4:0]  host_len;
        logic        bank;
    } t_summary;

endpackage

@@ hdl/dhcp_front.sv @@
// ----------------------------------------------------------------------------
// DHCP front end
// Walks header and options one byte per cycle when not stalled, writes
// hostname bytes to bank memory, hands the queue a summary on the last byte.
// ----------------------------------------------------------------------------
module dhcp_front #(
    parameter int HOST_CAP = 31,
    parameter int MIN_LEN  = 240,
    parameter int AW       = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_packet,
    output logic                  o_sum_valid,
    input  logic                  i_sum_ready,
    input  logic                  i_host_busy,
    output dhcp_pkg::t_summary    o_sum,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [7:0]            o_wr_data
);
    import dhcp_pkg::*;

    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_VAL  = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    logic [7:0]  r_pos, n_pos;
    logic [9:0]  r_len, n_len;
    logic        r_good, n_good;
    t_phase      r_ph, n_ph;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_olen, n_olen;
    logic [7:0]  r_oidx, n_oidx;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_xid, n_xid;
    logic [15:0] r_flags, n_flags;
    logic [31:0] r_ci, n_ci;
    logic [47:0] r_mac, n_mac;
    logic [7:0]  r_mt, n_mt;
    logic [31:0] r_rq, n_rq;
    logic [31:0] r_sv, n_sv;
    logic        r_bank, n_bank;
    logic [4:0]  r_hcnt, n_hcnt;
    logic        fire, apply, host_wr;
    logic [31:0] aval;
    logic [7:0]  b;

    // A hostname byte waits while an earlier hostname is still being sent.
    assign host_wr     = (r_pos >= 8'(OPT_START)) && (r_ph == PH_VAL) &&
                         (r_code == OPT_HOST) && (r_oidx < 8'(HOST_CAP));
    assign o_ready     = i_sum_ready && !(host_wr && i_host_busy);
    assign fire        = i_valid && o_ready;
    assign o_sum_valid = fire && i_end_of_packet;
    assign b           = i_data_byte;

    always_comb begin
        n_pos = r_pos; n_len = r_len; n_good = r_good; n_ph = r_ph;
        n_code = r_code; n_olen = r_olen; n_oidx = r_oidx; n_shift = r_shift;
        n_xid = r_xid; n_flags = r_flags; n_ci = r_ci; n_mac = r_mac;
        n_mt = r_mt; n_rq = r_rq; n_sv = r_sv; n_bank = r_bank; n_hcnt = r_hcnt;
        apply = 1'b0; aval = r_shift;
        o_wr_en = 1'b0;
        o_wr_addr = AW'(r_oidx) + (r_bank ? '0 : AW'(HOST_CAP));
        o_wr_data = b;
        if (r_pos < 8'(OPT_START)) begin
            if (r_pos == 8'd0 && b != 8'd1) n_good = 1'b0;
            if (r_pos == 8'd2 && b != 8'd6) n_good = 1'b0;
            if (r_pos == 8'd236 && b != COOKIE_0) n_good = 1'b0;
            if (r_pos == 8'd237 && b != COOKIE_1) n_good = 1'b0;
            if (r_pos == 8'd238 && b != COOKIE_2) n_good = 1'b0;
            if (r_pos == 8'd239 && b != COOKIE_3) n_good = 1'b0;
            if (r_pos >= 8'd4 && r_pos <= 8'd7) n_xid = {r_xid[23:0], b};
            if (r_pos >= 8'd10 && r_pos <= 8'd11) n_flags = {r_flags[7:0], b};
            if (r_pos >= 8'd12 && r_pos <= 8'd15) n_ci = {r_ci[23:0], b};
            if (r_pos >= 8'd28 && r_pos <= 8'd33) n_mac = {r_mac[39:0], b};
            n_pos = r_pos + 8'd1;
        end else begin
            unique case (r_ph)
                PH_CODE: begin
                    if (b == OPT_END) n_ph = PH_DONE;
                    else if (b != OPT_PAD) begin
                        n_code = b;
                        n_ph = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_olen = b; n_oidx = '0; n_shift = '0;
                    if (b == 8'd0) begin
                        apply = 1'b1; aval = '0; n_ph = PH_CODE;
                    end else n_ph = PH_VAL;
                end
                PH_VAL: begin
                    o_wr_en = host_wr && fire;
                    if (r_code == OPT_MSG) begin
                        if (r_oidx == 8'd0) n_shift = {24'd0, b};
                    end else n_shift = {r_shift[23:0], b};
                    n_oidx = r_oidx + 8'd1;
                    aval = n_shift;
                    if (n_oidx >= r_olen) begin
                        apply = 1'b1; n_ph = PH_CODE;
                    end
                end
                default: ;
            endcase
        end
        if (apply) begin
            if (r_code == OPT_MSG && n_olen >= 8'd1) n_mt = aval[7:0];
            if (r_code == OPT_REQIP && n_olen == 8'd4) n_rq = aval;
            if (r_code == OPT_SRVID && n_olen == 8'd4) n_sv = aval;
            if (r_code == OPT_HOST) begin
                n_bank = ~r_bank;
                n_hcnt = (n_olen < 8'(HOST_CAP)) ? n_olen[4:0] : 5'(HOST_CAP);
            end
        end
        if (r_len != 10'(LEN_SAT)) n_len = r_len + 10'd1;
    end

    always_comb begin
        o_sum.ok = r_good && n_pos >= 8'(OPT_START) && {1'b0, n_len} >= 11'(MIN_LEN);
        o_sum.xid      = n_xid;
        o_sum.flags    = n_flags;
        o_sum.ciaddr   = n_ci;
        o_sum.mac      = n_mac;
        o_sum.msg_type = n_mt;
        o_sum.req_ip   = n_rq;
        o_sum.srv_id   = n_sv;
        o_sum.host_len = n_hcnt;
        o_sum.bank     = n_bank;
        if (!n_good) o_sum.ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
        end else if (fire) begin
            r_bank <= n_bank;
        end
        if (!i_rst_n || (fire && i_end_of_packet)) begin
            r_pos <= '0; r_len <= '0; r_good <= 1'b1; r_ph <= PH_CODE;
            r_code <= '0; r_olen <= '0; r_oidx <= '0; r_shift <= '0;
            r_xid <= '0; r_flags <= '0; r_ci <= '0; r_mac <= '0;
            r_mt <= '0; r_rq <= '0; r_sv <= '0; r_hcnt <= '0;
        end else if (fire) begin
            r_pos <= n_pos; r_len <= n_len; r_good <= n_good; r_ph <= n_ph;
            r_code <= n_code; r_olen <= n_olen; r_oidx <= n_oidx; r_shift <= n_shift;
            r_xid <= n_xid; r_flags <= n_flags; r_ci <= n_ci; r_mac <= n_mac;
            r_mt <= n_mt; r_rq <= n_rq; r_sv <= n_sv; r_hcnt <= n_hcnt;
        end
    end

endmodule

@@ hdl/dhcp_queue.sv @@
// ----------------------------------------------------------------------------
// DHCP summary queue
// Two-entry queue of summary records between front end and emitter.
// ----------------------------------------------------------------------------
module dhcp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dhcp_pkg::t_summary i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output dhcp_pkg::t_summary o_data
);
    import dhcp_pkg::*;

    t_summary   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ hdl/dhcp_emit.sv @@
// ----------------------------------------------------------------------------
// DHCP result emitter
// Sends the summary, then, while the receiver is ready, reads the committed
// bank one byte per cycle into a registered output stage.
// ----------------------------------------------------------------------------
module dhcp_emit #(
    parameter int HOST_CAP = 31,
    parameter int AW       = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dhcp_pkg::t_summary i_sum,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [7:0]         i_wr_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_item_kind,
    output dhcp_pkg::t_summary o_sum,
    output logic [7:0]         o_host_byte,
    output logic               o_last,
    output logic               o_run
);
    import dhcp_pkg::*;

    logic [7:0]    r_mem [2*HOST_CAP];
    logic [7:0]    r_rd;
    logic          r_v, r_kind, r_last, r_run, r_bank;
    t_summary      r_sum;
    logic [4:0]    r_idx, r_cnt;
    logic          adv, take, step;
    logic [AW-1:0] rd_addr;

    assign adv     = !r_v || i_ready;
    assign take    = adv && !r_run && i_valid;
    assign step    = adv && r_run;
    assign o_ready = adv && !r_run;
    assign rd_addr = AW'(r_idx) + (r_bank ? AW'(HOST_CAP) : '0);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (step) r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0; r_run <= 1'b0;
        end else if (take) begin
            r_v <= 1'b1;
            r_run <= i_sum.ok && i_sum.host_len != 5'd0;
        end else if (step) begin
            r_v <= 1'b1;
            if (r_idx + 5'd1 == r_cnt) r_run <= 1'b0;
        end else if (adv) begin
            r_v <= 1'b0;
        end
        if (take) begin
            r_kind <= 1'b0;
            r_sum  <= i_sum.ok ? i_sum : '0;
            r_last <= !(i_sum.ok && i_sum.host_len != 5'd0);
            r_idx  <= '0;
            r_cnt  <= i_sum.host_len;
            r_bank <= i_sum.bank;
        end else if (step) begin
            r_kind <= 1'b1;
            r_sum  <= '0;
            r_last <= (r_idx + 5'd1 == r_cnt);
            r_idx  <= r_idx + 5'd1;
        end
    end

    assign o_valid     = r_v;
    assign o_item_kind = r_kind;
    assign o_sum       = r_sum;
    assign o_host_byte = r_kind ? r_rd : 8'd0;
    assign o_last      = r_last;
    assign o_run       = r_run;

endmodule

@@ hdl/dhcp_request_parser.sv @@
// ----------------------------------------------------------------------------
// DHCP request parser
// Checks a BOOTP/DHCP request byte stream and reports a summary and hostname.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  in       input      one packet byte with last-byte flag
//  out      output     summary result, then hostname bytes
//
// A byte is taken every cycle while the summary queue has room; a hostname
// byte also waits while an earlier hostname is queued or still being sent.
// The emitter sends a summary and then, while the receiver is ready, one
// hostname byte per cycle from the bank memory. Reset is synchronous and
// clears the parser, queue pointer and valid/run state; the hostname memory
// is not cleared. Either side may stall without losing transactions.
module dhcp_request_parser
    import dhcp_pkg::*;
#(
    parameter int HOSTNAME_MAX = HOSTNAME_MAX_DEF,
    parameter int MIN_LEN      = MIN_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_item_kind,
    output logic        o_ok,
    output logic [31:0] o_transaction_id,
    output logic [15:0] o_bootp_flags,
    output logic [31:0] o_client_ip,
    output logic [47:0] o_client_mac,
    output logic [7:0]  o_message_type,
    output logic [31:0] o_requested_address,
    output logic [31:0] o_server_identifier,
    output logic [4:0]  o_host_length,
    output logic [7:0]  o_host_byte,
    output logic        o_last_of_run
);
    localparam int HOST_CAP = (HOSTNAME_MAX > 31) ? 31 : HOSTNAME_MAX;
    localparam int AW       = $clog2(2 * HOST_CAP);

    t_summary      fe_sum, q_sum, em_sum;
    logic          fe_v, fe_r, q_v, q_r, wr_en, em_run, host_busy;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign host_busy = q_v || em_run;

    dhcp_front #(.HOST_CAP(HOST_CAP), .MIN_LEN(MIN_LEN), .AW(AW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_end_of_packet,
        .o_sum_valid(fe_v), .i_sum_ready(fe_r), .i_host_busy(host_busy), .o_sum(fe_sum),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data)
    );

    dhcp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fe_v), .o_ready(fe_r), .i_data(fe_sum),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_sum)
    );

    dhcp_emit #(.HOST_CAP(HOST_CAP), .AW(AW)) u_emit (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_sum(q_sum),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .o_valid, .i_ready, .o_item_kind, .o_sum(em_sum), .o_host_byte,
        .o_last(o_last_of_run), .o_run(em_run)
    );

    assign o_ok                = em_sum.ok;
    assign o_transaction_id    = em_sum.xid;
    assign o_bootp_flags       = em_sum.flags;
    assign o_client_ip         = em_sum.ciaddr;
    assign o_client_mac        = em_sum.mac;
    assign o_message_type      = em_sum.msg_type;
    assign o_requested_address = em_sum.req_ip;
    assign o_server_identifier = em_sum.srv_id;
    assign o_host_length       = em_sum.host_len;

endmodule

@@ tb/dhcp_request_parser_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DHCP request parser checker
// Watches both channels, predicts the summary and hostname results of every
// accepted byte, and compares each accepted output transaction in order.
// ----------------------------------------------------------------------------
module dhcp_request_parser_checker
    import dhcp_pkg::*;
#(
    parameter int HOSTNAME_MAX = HOSTNAME_MAX_DEF,
    parameter int MIN_LEN      = MIN_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    input  logic        i_valid_out,
    input  logic        i_ready,
    input  logic        i_item_kind,
    input  logic        i_ok,
    input  logic [31:0] i_transaction_id,
    input  logic [15:0] i_bootp_flags,
    input  logic [31:0] i_client_ip,
    input  logic [47:0] i_client_mac,
    input  logic [7:0]  i_message_type,
    input  logic [31:0] i_requested_address,
    input  logic [31:0] i_server_identifier,
    input  logic [4:0]  i_host_length,
    input  logic [7:0]  i_host_byte,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen,
    output int          o_hosts_seen
);

    localparam int HOST_CAP = (HOSTNAME_MAX > 31) ? 31 : HOSTNAME_MAX;

    typedef enum logic [1:0] {WALK_CODE, WALK_LEN, WALK_VAL, WALK_DONE} t_walk;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [31:0] xid;
        logic [15:0] flags;
        logic [31:0] ciaddr;
        logic [47:0] mac;
        logic [7:0]  msg;
        logic [31:0] req;
        logic [31:0] srv;
        logic [4:0]  hlen;
        logic [7:0]  hbyte;
        logic        last;
    } t_result;

    t_result     expected_results[$];
    logic [7:0]  pos;
    int          len_cnt;
    logic        hdr_good;
    t_walk       walk;
    logic [7:0]  code, opt_len, opt_idx;
    logic [31:0] shift_val;
    logic [31:0] xid, ciaddr, req, srv;
    logic [15:0] flags;
    logic [7:0]  msg;
    logic [47:0] mac;
    logic [7:0]  hosts[2][32];
    logic        bank;
    logic [4:0]  hcount;

    assign o_pending = expected_results.size();

    task automatic clear_packet();
        pos = 0; len_cnt = 0; hdr_good = 1; walk = WALK_CODE;
        code = 0; opt_len = 0; opt_idx = 0; shift_val = 0;
        xid = 0; ciaddr = 0; req = 0; srv = 0; flags = 0; msg = 0; mac = 0;
        hcount = 0;
    endtask

    task automatic commit_option();
        case (code)
            OPT_MSG:   if (opt_len >= 1) msg = shift_val[7:0];
            OPT_REQIP: if (opt_len == 4) req = shift_val;
            OPT_SRVID: if (opt_len == 4) srv = shift_val;
            OPT_HOST: begin
                bank   = ~bank;
                hcount = (opt_len < HOST_CAP) ? opt_len[4:0] : 5'(HOST_CAP);
            end
            default: ;
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        t_result r;
        logic    good;
        if (pos < OPT_START) begin
            if (pos == 0 && b != 8'd1) hdr_good = 0;
            if (pos == 2 && b != 8'd6) hdr_good = 0;
            if (pos == 236 && b != COOKIE_0) hdr_good = 0;
            if (pos == 237 && b != COOKIE_1) hdr_good = 0;
            if (pos == 238 && b != COOKIE_2) hdr_good = 0;
            if (pos == 239 && b != COOKIE_3) hdr_good = 0;
            if (pos >= 4 && pos <= 7) xid = {xid[23:0], b};
            if (pos >= 10 && pos <= 11) flags = {flags[7:0], b};
            if (pos >= 12 && pos <= 15) ciaddr = {ciaddr[23:0], b};
            if (pos >= 28 && pos <= 33) mac = {mac[39:0], b};
            pos++;
        end else begin
            case (walk)
                WALK_CODE: begin
                    if (b == OPT_END) walk = WALK_DONE;
                    else if (b != OPT_PAD) begin
                        code = b;
                        walk = WALK_LEN;
                    end
                end
                WALK_LEN: begin
                    opt_len = b; opt_idx = 0; shift_val = 0;
                    if (b == 0) begin
                        commit_option();
                        walk = WALK_CODE;
                    end else begin
                        walk = WALK_VAL;
                    end
                end
                WALK_VAL: begin
                    if (code == OPT_HOST && opt_idx < HOST_CAP) hosts[~bank][opt_idx] = b;
                    if (code == OPT_MSG) begin
                        if (opt_idx == 0) shift_val = b;
                    end else begin
                        shift_val = {shift_val[23:0], b};
                    end
                    opt_idx++;
                    if (opt_idx >= opt_len) begin
                        commit_option();
                        walk = WALK_CODE;
                    end
                end
                default: ;
            endcase
        end
        if (len_cnt < LEN_SAT) len_cnt++;
        if (eop) begin
            good = hdr_good && pos >= OPT_START && len_cnt >= MIN_LEN;
            r = '0;
            r.ok = good;
            if (good) begin
                r.xid = xid; r.flags = flags; r.ciaddr = ciaddr; r.mac = mac;
                r.msg = msg; r.req = req; r.srv = srv; r.hlen = hcount;
            end
            r.last = !(good && hcount > 0);
            expected_results.push_back(r);
            if (good) begin
                for (int k = 0; k < hcount; k++) begin
                    r = '0;
                    r.kind  = 1;
                    r.hbyte = hosts[bank][k];
                    r.last  = (k + 1 == hcount);
                    expected_results.push_back(r);
                end
            end
            clear_packet();
        end
    endtask

    task automatic compare(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            clear_packet();
            bank = 0;
            expected_results.delete();
            o_fail_count   = 0;
            o_results_seen = 0;
            o_hosts_seen   = 0;
        end else begin
            if (i_valid_out && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Unexpected output transaction");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    compare("item_kind", e.kind, i_item_kind);
                    compare("ok", e.ok, i_ok);
                    compare("transaction_id", e.xid, i_transaction_id);
                    compare("bootp_flags", e.flags, i_bootp_flags);
                    compare("client_ip", e.ciaddr, i_client_ip);
                    compare("client_mac", e.mac, i_client_mac);
                    compare("message_type", e.msg, i_message_type);
                    compare("requested_address", e.req, i_requested_address);
                    compare("server_identifier", e.srv, i_server_identifier);
                    compare("host_length", e.hlen, i_host_length);
                    compare("host_byte", e.hbyte, i_host_byte);
                    compare("last_of_run", e.last, i_last_of_run);
                    if (e.kind) o_hosts_seen++;
                    else o_results_seen++;
                end
            end
            if (i_valid && i_ready_in) parse_byte(i_data_byte, i_end_of_packet);
        end
    end

endmodule

@@ tb/dhcp_request_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DHCP request parser testbench
// Sends directed and short random packets with bursty input and a stalling
// receiver; the checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module dhcp_request_parser_tb;
    import dhcp_pkg::*;

    localparam int CYCLE_LIMIT = 20000;

    logic        i_clk, i_rst_n, i_valid, o_ready, i_end_of_packet;
    logic [7:0]  i_data_byte;
    logic        o_valid, i_ready, o_item_kind, o_ok, o_last_of_run;
    logic [31:0] o_transaction_id, o_client_ip, o_requested_address, o_server_identifier;
    logic [15:0] o_bootp_flags;
    logic [47:0] o_client_mac;
    logic [7:0]  o_message_type, o_host_byte;
    logic [4:0]  o_host_length;
    int          fail_count, pending, results_seen, hosts_seen;
    int          cycles, bytes_sent;
    logic        long_hold;
    logic [7:0]  pkt[$];

    dhcp_request_parser dut (.*);

    dhcp_request_parser_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_data_byte, .i_end_of_packet,
        .i_valid_out(o_valid), .i_ready, .i_item_kind(o_item_kind), .i_ok(o_ok),
        .i_transaction_id(o_transaction_id), .i_bootp_flags(o_bootp_flags),
        .i_client_ip(o_client_ip), .i_client_mac(o_client_mac),
        .i_message_type(o_message_type), .i_requested_address(o_requested_address),
        .i_server_identifier(o_server_identifier), .i_host_length(o_host_length),
        .i_host_byte(o_host_byte), .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_hosts_seen(hosts_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (long_hold) i_ready <= 0;
        else if (($urandom_range(0, 63) < 32) && ($urandom_range(0, 3) == 0)) i_ready <= 0;
        else i_ready <= ($urandom_range(0, 7) != 0) || (cycles % 512 < 128);
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        i_valid <= 1;
        i_data_byte <= b;
        i_end_of_packet <= eop;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // Sends the queued packet, in bursts if bursty; last byte carries the end flag.
    task automatic send_packet(input bit bursty);
        int burst;
        burst = $urandom_range(1, 60);
        for (int k = 0; k < pkt.size(); k++) begin
            send_byte(pkt[k], k == pkt.size() - 1);
            if (bursty && --burst == 0) begin
                i_valid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = $urandom_range(1, 60);
            end
        end
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic build_header(input bit corrupt);
        pkt.delete();
        for (int k = 0; k < OPT_START; k++) pkt.push_back(8'($urandom_range(0, 255)));
        pkt[0] = 8'd1; pkt[2] = 8'd6;
        pkt[236] = COOKIE_0; pkt[237] = COOKIE_1; pkt[238] = COOKIE_2; pkt[239] = COOKIE_3;
        if (corrupt) pkt[$urandom_range(0, 5) == 0 ? 0 :
                         ($urandom_range(0, 1) ? 2 : $urandom_range(236, 239))] ^=
                         8'($urandom_range(1, 255));
    endtask

    task automatic add_option(input logic [7:0] code, input int len);
        pkt.push_back(code);
        pkt.push_back(8'(len));
        for (int k = 0; k < len; k++) pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        bytes_sent = 0; long_hold = 0;
        i_rst_n = 0; i_valid = 0; i_data_byte = 0; i_end_of_packet = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed packets: a stray byte, then one full request with pad, repeated
        // and bad-length addresses, a long hostname and a cut-off hostname.
        pkt = '{8'hFF}; send_packet(0);
        build_header(0); pkt.push_back(OPT_PAD); add_option(OPT_MSG, 3);
        add_option(OPT_REQIP, 4); add_option(OPT_SRVID, 4); add_option(OPT_SRVID, 3);
        add_option(OPT_HOST, 40); add_option(OPT_HOST, 6); void'(pkt.pop_back());
        send_packet(1);
        wait (pending == 0);

        // Long receiver hold while the sender keeps going.
        fork
            begin
                long_hold = 1;
                repeat (600) @(posedge i_clk);
                long_hold = 0;
            end
            repeat (8) begin
                pkt.delete();
                repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
                send_packet(0);
            end
        join
        wait (pending == 0);

        while (bytes_sent < 380) begin
            pkt.delete();
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
            send_packet($urandom_range(0, 1));
        end

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d bytes; checked %0d summaries and %0d hostname bytes.",
                 bytes_sent, results_seen, hosts_seen);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/dhcp_pkg.sv
hdl/dhcp_front.sv
hdl/dhcp_queue.sv
hdl/dhcp_emit.sv
hdl/dhcp_request_parser.sv
tb/dhcp_request_parser_checker.sv
tb/dhcp_request_parser_tb.sv
